### sv/sil_pkg.sv
package sil_pkg;

    localparam int CAPACITY_DEFAULT = 128;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_LOOKUP  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEARCH,
        ST_UPDATE
    } sil_state_t;

    typedef struct packed {
        logic compare;
        logic strict;
        logic ins;
        logic del;
        logic rep;
    } cell_ctrl_t;

endpackage

### sv/sil_cell.sv
module sil_cell import sil_pkg::*; #(
    parameter int CW    = 8,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [CW-1:0]      pos,
    input  logic [CW-1:0]      count,
    input  logic signed [31:0] key,
    input  logic signed [31:0] prev_value,
    input  logic signed [31:0] next_value,
    output logic signed [31:0] value,
    output logic               flag,
    output logic               equal
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               flag_reg;
    logic               flag_next;
    logic               equal_reg;
    logic               equal_next;
    logic               in_list;

    assign in_list = IDX < count;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (IDX > pos)
            begin
                value_next = prev_value;
            end
            else if (IDX == pos)
            begin
                value_next = key;
            end
        end
        else if (ctrl.del)
        begin
            if (IDX >= pos)
            begin
                value_next = next_value;
            end
        end
        else if (ctrl.rep)
        begin
            if (IDX == pos)
            begin
                value_next = key;
            end
        end
    end

    always_comb
    begin
        flag_next  = flag_reg;
        equal_next = equal_reg;
        if (ctrl.compare)
        begin
            flag_next  = in_list && (ctrl.strict ? (value_reg <= key) : (value_reg < key));
            equal_next = value_reg == key;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        flag_reg  <= flag_next;
        equal_reg <= equal_next;
    end

    assign value = value_reg;
    assign flag  = flag_reg;
    assign equal = equal_reg;

endmodule

### sv/sorted_int_list_table.sv
// Sorted table of up to CAPACITY signed 32-bit values held in ascending order.
// The input channel takes one word per operation: an operation code (insert,
// lookup, delete, replace, clear) and a key. The output channel returns one
// word per operation: a success flag, the position acted on, and the length.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. One operation is in progress at a time and in_stall stays high
// while it is. Each value sits in its own cell of a chain; all cells compare
// the key at once, then a binary search over the compare flags finds the
// position in at most ceil(log2(length + 1)) steps, and the cells shift by
// one place toward or away from their neighbor to insert or delete. An
// operation passes through the compare, search and update states before the
// next acceptance. The result shows on the output in the same cycle in which
// in_stall drops again. A finished result waits in the output register while
// out_stall is high; an operation that finishes while it still waits holds
// its own result back, and the input stays stalled, until the waiting word is
// taken. Reset empties the list at once.
module sorted_int_list_table import sil_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic signed [31:0] key_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [7:0]         position,
    output logic [7:0]         list_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    sil_state_t         state_reg;
    sil_state_t         state_next;
    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      lo_next;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      hi_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               ok_reg;
    logic               ok_next;
    logic [7:0]         position_reg;
    logic [7:0]         position_next;
    logic [7:0]         list_length_reg;
    logic [7:0]         list_length_next;

    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic               found;
    logic               out_free;
    logic               accept;
    cell_ctrl_t         ctrl;

    logic signed [31:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] flag_vec;
    logic [CAPACITY-1:0] equal_vec;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] prev_value;
            logic signed [31:0] next_value;
            if (gi == 0)
            begin : g_first
                assign prev_value = key_reg;
            end
            else
            begin : g_mid
                assign prev_value = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_value = cell_value[gi];
            end
            else
            begin : g_inner
                assign next_value = cell_value[gi+1];
            end
            sil_cell #(
                .CW    (CW),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (lo_reg),
                .count      (count_reg),
                .key        (key_reg),
                .prev_value (prev_value),
                .next_value (next_value),
                .value      (cell_value[gi]),
                .flag       (flag_vec[gi]),
                .equal      (equal_vec[gi])
            );
        end
    endgenerate

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW:1];
    assign found    = (lo_reg < count_reg) && equal_vec[lo_reg[IW-1:0]];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall         = 1'b1;
        ctrl             = '0;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        count_next       = count_reg;
        ok_next          = ok_reg;
        position_next    = position_reg;
        list_length_next = list_length_reg;
        out_valid_next   = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_CMP:
            begin
                ctrl.compare = 1'b1;
                ctrl.strict  = op_reg == OP_INSERT;
                lo_next      = '0;
                hi_next      = count_reg;
            end
            ST_SEARCH:
            begin
                if (lo_reg != hi_reg)
                begin
                    if (flag_vec[mid[IW-1:0]])
                    begin
                        lo_next = mid + CW'(1);
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    ok_next        = 1'b0;
                    position_next  = '0;
                    out_valid_next = 1'b1;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (count_reg < CAP)
                            begin
                                ok_next       = 1'b1;
                                position_next = 8'(lo_reg);
                                ctrl.ins      = 1'b1;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        OP_LOOKUP, OP_DELETE, OP_REPLACE:
                        begin
                            if (found)
                            begin
                                ok_next       = 1'b1;
                                position_next = 8'(lo_reg);
                                if (op_reg == OP_DELETE)
                                begin
                                    ctrl.del   = 1'b1;
                                    count_next = count_reg - CW'(1);
                                end
                                else if (op_reg == OP_REPLACE)
                                begin
                                    ctrl.rep = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    list_length_next = 8'(count_next);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= key_value;
        end
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        ok_reg          <= ok_next;
        position_reg    <= position_next;
        list_length_reg <= list_length_next;
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign position    = position_reg;
    assign list_length = list_length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("stored count exceeds capacity");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search bounds out of order");

    a_length_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (list_length_reg == 8'(count_reg)))
        else $error("reported length differs from stored count");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (in_stall && state_reg == ST_CMP))
        else $error("input not held off after accepting a word");

endmodule

### tb/tb_sorted_int_list_table.sv
`timescale 1ns / 1ps

module tb_sorted_int_list_table;
    import sil_pkg::*;

    localparam int CAPACITY = CAPACITY_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 80;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_MID = 3'd6;
    localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

    typedef struct {
        logic       ok;
        logic [7:0] position;
        logic [7:0] length;
    } list_result_t;

    class sorted_list_scoreboard;
        logic signed [31:0] values [CAPACITY];
        int                 num_values;
        list_result_t       expected_results [$];
        int                 mismatches;

        function new();
            num_values = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic signed [31:0] stored_key();
            return values[$urandom_range(num_values - 1)];
        endfunction

        // Updates the list for one accepted word and queues the result it must produce.
        function void note_word(input logic [2:0] op, input logic signed [31:0] key);
            list_result_t res;
            int           at;
            int           i;
            res.ok = 1'b0;
            res.position = 8'd0;
            case (op)
                OP_INSERT:
                begin
                    if (num_values < CAPACITY)
                    begin
                        at = 0;
                        while (at < num_values && values[at] <= key)
                            at++;
                        for (i = num_values; i > at; i--)
                            values[i] = values[i - 1];
                        values[at] = key;
                        num_values++;
                        res.ok = 1'b1;
                        res.position = at[7:0];
                    end
                end
                OP_LOOKUP, OP_DELETE, OP_REPLACE:
                begin
                    at = 0;
                    while (at < num_values && values[at] < key)
                        at++;
                    if (at < num_values && values[at] == key)
                    begin
                        res.ok = 1'b1;
                        res.position = at[7:0];
                        if (op == OP_DELETE)
                        begin
                            for (i = at; i + 1 < num_values; i++)
                                values[i] = values[i + 1];
                            num_values--;
                        end
                        else if (op == OP_REPLACE)
                        begin
                            values[at] = key;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    num_values = 0;
                    res.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            res.length = num_values[7:0];
            expected_results.push_back(res);
        endfunction

        function void check_word(input logic ok, input logic [7:0] position,
                                 input logic [7:0] length);
            list_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: ok=%0d position=%0d length=%0d",
                             ok, position, length);
                return;
            end
            exp_res = expected_results.pop_front();
            if (ok !== exp_res.ok || position !== exp_res.position
                || length !== exp_res.length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected ok=%0d position=%0d length=%0d, got ok=%0d position=%0d length=%0d",
                             exp_res.ok, exp_res.position, exp_res.length,
                             ok, position, length);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         operation = OP_INSERT;
    logic signed [31:0] key_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic [7:0]         position;
    logic [7:0]         list_length;

    sorted_list_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    sorted_int_list_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .key_value(key_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok(ok),
        .position(position),
        .list_length(list_length)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_word(input logic [2:0] op, input logic signed [31:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        key_value <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(op, key);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic [2:0] random_op();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return OP_INSERT;
        else if (r < 55)
            return OP_LOOKUP;
        else if (r < 72)
            return OP_DELETE;
        else if (r < 85)
            return OP_REPLACE;
        else if (r < 89)
            return OP_CLEAR;
        else
            return 3'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
    endfunction

    function automatic logic signed [31:0] random_key();
        int r;
        r = $urandom_range(99);
        if (r < 40 || (r < 65 && sb.num_values == 0))
            return $urandom_range(16) - 8;
        else if (r < 65)
            return sb.stored_key();
        else if (r < 75)
        begin
            case ($urandom_range(5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                3: return KEY_MAX - 1;
                4: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_random(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_word(random_op(), random_key());
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_word(ok, position, list_length);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int k;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 63;
        send_word(OP_LOOKUP, 0);
        send_word(OP_DELETE, 5);
        send_word(OP_REPLACE, 5);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, KEY_MAX);
        send_word(OP_INSERT, KEY_MIN);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, -1);
        send_word(OP_LOOKUP, 0);
        send_word(OP_LOOKUP, KEY_MIN);
        send_word(OP_LOOKUP, KEY_MAX);
        send_word(OP_LOOKUP, 1);
        send_word(OP_REPLACE, 0);
        send_word(OP_REPLACE, KEY_MAX);
        send_word(OP_DELETE, 0);
        send_word(OP_DELETE, KEY_MAX);
        send_word(OP_DELETE, KEY_MIN);
        send_word(OP_UNKNOWN_LO, 32'sh5555_5555);
        send_word(OP_UNKNOWN_MID, 32'shaaaa_aaaa);
        send_word(OP_UNKNOWN_HI, -1);
        send_word(OP_CLEAR, 32'sh1234_5678);
        send_word(OP_LOOKUP, 0);
        send_word(OP_INSERT, 1);
        send_word(OP_CLEAR, KEY_MIN);
        send_random(170);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 13;
        hold_request = 1'b1;
        for (k = 0; k < 12; k++)
            send_word(OP_INSERT, random_key());
        send_idle_pct = 63;
        send_random(170);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(OP_CLEAR, $urandom);
        for (k = 0; k < CAPACITY + 4; k++)
        begin
            if ($urandom_range(3) == 0)
                send_word(OP_INSERT, $urandom);
            else
                send_word(OP_INSERT, $urandom_range(40) - 20);
        end
        send_word(OP_LOOKUP, sb.stored_key());
        send_word(OP_LOOKUP, KEY_MAX);
        send_word(OP_REPLACE, sb.stored_key());
        send_word(OP_REPLACE, $urandom);
        send_word(OP_LOOKUP, sb.stored_key());
        send_word(OP_DELETE, $urandom);
        for (k = 0; k < 40; k++)
            send_word(OP_DELETE, sb.stored_key());
        send_word(OP_INSERT, KEY_MIN);
        send_word(OP_INSERT, KEY_MAX);
        send_random(60);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
